@@ src/slpdf_pkg.sv @@
// ============================================================================
// slpdf_pkg
// Shared types and constants for the sphere light sampling density block.
// ============================================================================
`default_nettype none

package slpdf_pkg;

    // Word width of every coordinate and of the density result
    localparam int WORD_BITS = 32;

    // floor(pi * 2^30)
    localparam int PI_BITS = 32;
    localparam logic [PI_BITS-1:0] PI_Q30 = 32'd3373259426;

    // Rough bit-product budget of one multiplier slice per stage
    localparam int MUL_AREA = 1100;

    // Configuration register map
    localparam int CFG_IDX_BITS = 2;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } t_cfg_reg;

    // One query
    typedef struct packed {
        logic signed [WORD_BITS-1:0] eye_x;
        logic signed [WORD_BITS-1:0] eye_y;
        logic signed [WORD_BITS-1:0] eye_z;
        logic signed [WORD_BITS-1:0] light_x;
        logic signed [WORD_BITS-1:0] light_y;
        logic signed [WORD_BITS-1:0] light_z;
        logic signed [WORD_BITS-1:0] dir_x;
        logic signed [WORD_BITS-1:0] dir_y;
        logic signed [WORD_BITS-1:0] dir_z;
    } t_item;

    // One answer
    typedef struct packed {
        logic [WORD_BITS-1:0] density;
        logic                 inside_sphere;
        logic                 saturated;
    } t_result;

endpackage

`default_nettype wire

@@ src/slpdf_dly.sv @@
// ============================================================================
// slpdf_dly
// Fixed-depth delay line used to line up operands between pipeline branches.
// ============================================================================
`default_nettype none

module slpdf_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);

    if (DEPTH == 0) begin : g_none
        assign o_d = i_d;
    end else begin : g_line
        logic [WIDTH-1:0] r_sh [DEPTH];

        // shift by one tap per clock
        always_ff @(posedge i_clk) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end

        assign o_d = r_sh[DEPTH-1];
    end

endmodule

`default_nettype wire

@@ src/slpdf_mul.sv @@
// ============================================================================
// slpdf_mul
// Pipelined unsigned multiplier: one DG-bit digit of b per stage.
// ============================================================================
`default_nettype none

module slpdf_mul #(
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int DG = 32
) (
    input  logic            i_clk,
    input  logic [WA-1:0]   i_a,
    input  logic [WB-1:0]   i_b,
    output logic [WA+WB-1:0] o_p
);

    localparam int NS = (WB + DG - 1) / DG;
    localparam int BP = NS * DG;
    localparam int PW = WA + WB;

    logic [WA-1:0] r_a   [NS];
    logic [BP-1:0] r_b   [NS];
    logic [PW-1:0] r_acc [NS];
    logic [BP-1:0] b_pad;

    assign b_pad = BP'(i_b);

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [WA-1:0]    a_in;
        logic [BP-1:0]    b_in;
        logic [PW-1:0]    acc_in;
        logic [WA+DG-1:0] pp;

        if (s == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = b_pad;
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[s-1];
            assign b_in   = r_b[s-1];
            assign acc_in = r_acc[s-1];
        end

        // partial product of this digit
        assign pp = {{DG{1'b0}}, a_in} * {{WA{1'b0}}, b_in[s*DG +: DG]};

        // last stage operands are not consumed and drop out in synthesis
        always_ff @(posedge i_clk) begin
            r_acc[s] <= acc_in + (PW'(pp) << (s * DG));
            r_a[s]   <= a_in;
            r_b[s]   <= b_in;
        end
    end

    assign o_p = r_acc[NS-1];

endmodule

`default_nettype wire

@@ src/slpdf_div.sv @@
// ============================================================================
// slpdf_div
// Pipelined restoring divider, one quotient bit per stage.
// Quotient is exact when the dividend is below divisor * 2^QB.
// ============================================================================
`default_nettype none

module slpdf_div #(
    parameter int ND = 64,
    parameter int DD = 32,
    parameter int QB = 32
) (
    input  logic          i_clk,
    input  logic [ND-1:0] i_num,
    input  logic [DD-1:0] i_den,
    output logic [QB-1:0] o_q
);

    localparam int XW = (ND > DD + QB) ? ND : DD + QB;

    logic [XW-1:0] r_rem [QB];
    logic [DD-1:0] r_den [QB];
    logic [QB-1:0] r_q   [QB];

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [XW-1:0] rem_in;
        logic [DD-1:0] den_in;
        logic [QB-1:0] q_in;
        logic [XW-1:0] sh;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_in = XW'(i_num);
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign q_in   = r_q[s-1];
        end

        // trial subtract of the shifted divisor
        assign sh = XW'(den_in) << (QB - 1 - s);
        assign ge = (rem_in >= sh);

        // last stage remainder is not consumed and drops out in synthesis
        always_ff @(posedge i_clk) begin
            r_q[s]   <= q_in | (QB'(ge) << (QB - 1 - s));
            r_rem[s] <= ge ? rem_in - sh : rem_in;
            r_den[s] <= den_in;
        end
    end

    assign o_q = r_q[QB-1];

endmodule

`default_nettype wire

@@ src/slpdf_sqrt.sv @@
// ============================================================================
// slpdf_sqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
`default_nettype none

module slpdf_sqrt #(
    parameter int NB = 16
) (
    input  logic            i_clk,
    input  logic [2*NB-1:0] i_x,
    output logic [NB-1:0]   o_root
);

    localparam int XW = 2 * NB;

    logic [XW-1:0] r_rem [NB];
    logic [XW-1:0] r_res [NB];

    for (genvar s = 0; s < NB; s++) begin : g_stage
        logic [XW-1:0] rem_in;
        logic [XW-1:0] res_in;
        logic [XW-1:0] one;
        logic [XW-1:0] trial;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_in = i_x;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign res_in = r_res[s-1];
        end

        // digit-by-digit step for bit NB-1-s
        assign one   = XW'(1) << (2 * (NB - 1 - s));
        assign trial = res_in + one;
        assign ge    = (rem_in >= trial);

        // last stage remainder is not consumed and drops out in synthesis
        always_ff @(posedge i_clk) begin
            r_res[s] <= ge ? (res_in >> 1) + one : (res_in >> 1);
            r_rem[s] <= ge ? rem_in - trial : rem_in;
        end
    end

    assign o_root = r_res[NB-1][NB-1:0];

endmodule

`default_nettype wire

@@ src/sphere_light_sample_pdf.sv @@
// ============================================================================
// sphere_light_sample_pdf
// Area-measure sampling density of a point on a spherical light.
// ============================================================================
// Usage:
//   Query channel: an item (eye, light point, direction) is taken on a clock
//   edge with start high and busy low. busy is high during reset and is
//   cleared at the edge after it, so afterwards a new query may be issued every cycle.
//   Result channel: o_valid strobes for one cycle with o_result; results
//   leave in query order and cannot be held off.
//   Config channel: i_cfg_valid / o_cfg_ready (ready whenever busy is low)
//   writes the sphere center and radius; write it only when no query is in
//   flight.
//   At the default FRAC_BITS the pipeline depth is set by the cone branch: a
//   2F-bit divider, a (2F+1)-bit square root and a multiplier by pi, then
//   the divisor multiplier and a WORD_BITS-bit divider.
//   Throughput: one query per cycle, every unit is fully pipelined.
//   Reset clears the valid pipeline, sets busy and loads center 0 and
//   radius 1.0.
// ============================================================================
`default_nettype none

module sphere_light_sample_pdf
    import slpdf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  t_item                   i_item,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0]    i_cfg_data,
    output logic                    o_valid,
    output t_result                 o_result
);

    localparam int W   = WORD_BITS;
    localparam int F2  = 2 * FRAC_BITS;
    localparam int SW  = 2 * W + 2;              // sum of three squares
    localparam int DTW = 2 * W + 1;              // |dot product|
    localparam int R2W = 2 * W - 2;              // radius squared

    // multiplier digit sizes
    localparam int DG_SQ = (MUL_AREA / W > W) ? W : MUL_AREA / W;
    localparam int NS_SQ = (W + DG_SQ - 1) / DG_SQ;
    localparam int DG_R2 = (MUL_AREA / (W - 1) > W - 1) ? W - 1 : MUL_AREA / (W - 1);
    localparam int DG_PR = (MUL_AREA / R2W > PI_BITS) ? PI_BITS : MUL_AREA / R2W;
    localparam int OMW   = F2 + 1;
    localparam int DG_PO = (MUL_AREA / OMW > PI_BITS) ? PI_BITS : MUL_AREA / OMW;
    localparam int NS_PO = (PI_BITS + DG_PO - 1) / DG_PO;
    localparam int NB2   = W + 1;
    localparam int DG_LD = (MUL_AREA / SW > NB2) ? NB2 : MUL_AREA / SW;
    localparam int NS_LD = (NB2 + DG_LD - 1) / DG_LD;
    localparam int POW   = OMW + PI_BITS;
    localparam int LDW   = SW + NB2;
    localparam int DG_FN = (MUL_AREA / POW > LDW) ? LDW : MUL_AREA / POW;
    localparam int NS_FN = (LDW + DG_FN - 1) / DG_FN;
    localparam int DW    = POW + LDW;

    // cone and distance branch timing
    localparam int ND1 = R2W + F2;
    localparam int NB1 = F2 + 1;
    localparam int TQ  = F2 + NB1 + 1 + NS_PO;
    localparam int TL  = NB2 + NS_LD;
    localparam int TM  = (TQ > TL) ? TQ : TL;

    // numerator and final check widths
    localparam int NSH = 4 * FRAC_BITS + 29;
    localparam int NW  = DTW + NSH;
    localparam int XW2 = (NW > DW + W) ? NW : DW + W;
    localparam logic [NW-1:0]  NUM_IN = NW'(1) << (3 * FRAC_BITS + 28);
    localparam logic [F2:0]    ONE_Q  = {1'b1, {F2{1'b0}}};

    // pipeline positions
    localparam int K3 = 2 + NS_SQ;
    localparam int KF = K3 + TM + NS_FN;
    localparam int KS = KF + 1;
    localparam int KO = KS + W + 1;

    function automatic logic [W-1:0] f_absdiff(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
        logic [W:0] d;
        logic [W:0] nd;
        d  = {a[W-1], a} - {b[W-1], b};
        nd = -d;
        return d[W] ? nd[W-1:0] : d[W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // control, configuration and input registers
    // ------------------------------------------------------------------
    logic                  r_busy;
    logic [KO:0]           r_vld;
    logic signed [W-1:0]   r_cen_x, r_cen_y, r_cen_z;
    logic [W-2:0]          r_radius;
    t_item                 r_item;
    logic                  accept;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign o_valid     = r_vld[KO];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_vld    <= '0;
            r_cen_x  <= '0;
            r_cen_y  <= '0;
            r_cen_z  <= '0;
            r_radius <= (W - 1)'(1) << FRAC_BITS;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[KO-1:0], accept};
            if (i_cfg_valid && !r_busy) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_CENTER_X: r_cen_x  <= i_cfg_data;
                    REG_CENTER_Y: r_cen_y  <= i_cfg_data;
                    REG_CENTER_Z: r_cen_z  <= i_cfg_data;
                    REG_RADIUS:   r_radius <= i_cfg_data[W-2:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= i_item;
    end

    // ------------------------------------------------------------------
    // radius products, recomputed continuously from the config
    // ------------------------------------------------------------------
    logic [R2W-1:0]         w_r2;
    logic [R2W+PI_BITS-1:0] w_pr2;

    slpdf_mul #(.WA(W - 1), .WB(W - 1), .DG(DG_R2)) u_mul_r2 (
        .i_clk (i_clk), .i_a (r_radius), .i_b (r_radius), .o_p (w_r2)
    );

    slpdf_mul #(.WA(R2W), .WB(PI_BITS), .DG(DG_PR)) u_mul_pr2 (
        .i_clk (i_clk), .i_a (w_r2), .i_b (PI_Q30), .o_p (w_pr2)
    );

    // ------------------------------------------------------------------
    // stage 1: coordinate differences as magnitudes
    // ------------------------------------------------------------------
    logic signed [W-1:0] eye_v [3];
    logic signed [W-1:0] lit_v [3];
    logic signed [W-1:0] dir_v [3];
    logic signed [W-1:0] cen_v [3];
    logic [W-1:0]        r_ec_m [3];
    logic [W-1:0]        r_lc_m [3];
    logic [W-1:0]        r_le_m [3];
    logic [W-1:0]        r_dir_m [3];
    logic [2:0]          r_neg;

    assign eye_v[0] = r_item.eye_x;
    assign eye_v[1] = r_item.eye_y;
    assign eye_v[2] = r_item.eye_z;
    assign lit_v[0] = r_item.light_x;
    assign lit_v[1] = r_item.light_y;
    assign lit_v[2] = r_item.light_z;
    assign dir_v[0] = r_item.dir_x;
    assign dir_v[1] = r_item.dir_y;
    assign dir_v[2] = r_item.dir_z;
    assign cen_v[0] = r_cen_x;
    assign cen_v[1] = r_cen_y;
    assign cen_v[2] = r_cen_z;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_ec_m[i]  <= f_absdiff(eye_v[i], cen_v[i]);
            r_lc_m[i]  <= f_absdiff(lit_v[i], cen_v[i]);
            r_le_m[i]  <= f_absdiff(lit_v[i], eye_v[i]);
            r_dir_m[i] <= f_absdiff(dir_v[i], '0);
            r_neg[i]   <= (lit_v[i] < cen_v[i]) ^ dir_v[i][W-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: squares and dot product terms, per axis
    // ------------------------------------------------------------------
    logic [2*W-1:0] w_sq_ec [3];
    logic [2*W-1:0] w_sq_lc [3];
    logic [2*W-1:0] w_sq_le [3];
    logic [2*W-1:0] w_dp    [3];
    logic [2:0]     w_neg_d;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        slpdf_mul #(.WA(W), .WB(W), .DG(DG_SQ)) u_sq_ec (
            .i_clk (i_clk), .i_a (r_ec_m[i]), .i_b (r_ec_m[i]), .o_p (w_sq_ec[i])
        );
        slpdf_mul #(.WA(W), .WB(W), .DG(DG_SQ)) u_sq_lc (
            .i_clk (i_clk), .i_a (r_lc_m[i]), .i_b (r_lc_m[i]), .o_p (w_sq_lc[i])
        );
        slpdf_mul #(.WA(W), .WB(W), .DG(DG_SQ)) u_sq_le (
            .i_clk (i_clk), .i_a (r_le_m[i]), .i_b (r_le_m[i]), .o_p (w_sq_le[i])
        );
        slpdf_mul #(.WA(W), .WB(W), .DG(DG_SQ)) u_dp (
            .i_clk (i_clk), .i_a (r_lc_m[i]), .i_b (r_dir_m[i]), .o_p (w_dp[i])
        );
    end

    slpdf_dly #(.WIDTH(3), .DEPTH(NS_SQ)) u_dly_neg (
        .i_clk (i_clk), .i_d (r_neg), .o_d (w_neg_d)
    );

    // ------------------------------------------------------------------
    // stage 3: sums, signed dot product, inside test
    // ------------------------------------------------------------------
    logic [SW-1:0]  n_l2, n_lc2, n_d2;
    logic [DTW-1:0] n_dot;
    logic           n_inside;
    logic [SW-1:0]  r_l2, r_lc2, r_d2;
    logic [DTW-1:0] r_dot;
    logic           r_inside;

    always_comb begin
        logic [SW-1:0] acc;
        logic [SW-1:0] nacc;
        n_l2  = SW'(w_sq_ec[0]) + SW'(w_sq_ec[1]) + SW'(w_sq_ec[2]);
        n_lc2 = SW'(w_sq_lc[0]) + SW'(w_sq_lc[1]) + SW'(w_sq_lc[2]);
        n_d2  = SW'(w_sq_le[0]) + SW'(w_sq_le[1]) + SW'(w_sq_le[2]);
        acc   = '0;
        for (int i = 0; i < 3; i++) begin
            acc = w_neg_d[i] ? acc - SW'(w_dp[i]) : acc + SW'(w_dp[i]);
        end
        nacc     = -acc;
        n_dot    = acc[SW-1] ? nacc[DTW-1:0] : acc[DTW-1:0];
        n_inside = (n_l2 <= SW'(w_r2));
    end

    always_ff @(posedge i_clk) begin
        r_l2     <= n_l2;
        r_lc2    <= n_lc2;
        r_d2     <= n_d2;
        r_dot    <= n_dot;
        r_inside <= n_inside;
    end

    // ------------------------------------------------------------------
    // cone branch: q = r^2/l^2, cos = sqrt(1 - q), omc = 1 - cos
    // ------------------------------------------------------------------
    logic [F2-1:0]      w_q;
    logic [F2:0]        w_qc;
    logic [2*NB1-1:0]   w_sq1_in;
    logic [NB1-1:0]     w_cs;
    logic [OMW-1:0]     r_omc;
    logic [POW-1:0]     w_po, w_po_d;

    slpdf_div #(.ND(ND1), .DD(SW), .QB(F2)) u_div_q (
        .i_clk (i_clk), .i_num ({w_r2, {F2{1'b0}}}), .i_den (r_l2), .o_q (w_q)
    );

    assign w_qc     = ONE_Q - {1'b0, w_q};
    assign w_sq1_in = {1'b0, w_qc, {F2{1'b0}}};

    slpdf_sqrt #(.NB(NB1)) u_sqrt_cos (
        .i_clk (i_clk), .i_x (w_sq1_in), .o_root (w_cs)
    );

    always_ff @(posedge i_clk) begin
        r_omc <= ONE_Q - w_cs;
    end

    slpdf_mul #(.WA(OMW), .WB(PI_BITS), .DG(DG_PO)) u_mul_po (
        .i_clk (i_clk), .i_a (r_omc), .i_b (PI_Q30), .o_p (w_po)
    );

    slpdf_dly #(.WIDTH(POW), .DEPTH(TM - TQ)) u_dly_po (
        .i_clk (i_clk), .i_d (w_po), .o_d (w_po_d)
    );

    // ------------------------------------------------------------------
    // distance branch: |light - c| * |light - eye|^2
    // ------------------------------------------------------------------
    logic [NB2-1:0] w_len;
    logic [SW-1:0]  w_d2_d;
    logic [LDW-1:0] w_ld, w_ld_d;

    slpdf_sqrt #(.NB(NB2)) u_sqrt_len (
        .i_clk (i_clk), .i_x (r_lc2), .o_root (w_len)
    );

    slpdf_dly #(.WIDTH(SW), .DEPTH(NB2)) u_dly_d2 (
        .i_clk (i_clk), .i_d (r_d2), .o_d (w_d2_d)
    );

    slpdf_mul #(.WA(SW), .WB(NB2), .DG(DG_LD)) u_mul_ld (
        .i_clk (i_clk), .i_a (w_d2_d), .i_b (w_len), .o_p (w_ld)
    );

    slpdf_dly #(.WIDTH(LDW), .DEPTH(TM - TL)) u_dly_ld (
        .i_clk (i_clk), .i_d (w_ld), .o_d (w_ld_d)
    );

    // full outside divisor
    logic [DW-1:0] w_den_out;

    slpdf_mul #(.WA(POW), .WB(LDW), .DG(DG_FN)) u_mul_fn (
        .i_clk (i_clk), .i_a (w_po_d), .i_b (w_ld_d), .o_p (w_den_out)
    );

    // dot product and inside flag wait for the divisor
    logic [DTW:0] w_di_d;

    slpdf_dly #(.WIDTH(DTW + 1), .DEPTH(TM + NS_FN)) u_dly_di (
        .i_clk (i_clk), .i_d ({r_inside, r_dot}), .o_d (w_di_d)
    );

    // ------------------------------------------------------------------
    // select: numerator, divisor, zero divisor and overflow check
    // ------------------------------------------------------------------
    logic [NW-1:0] n_num;
    logic [DW-1:0] n_den;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic          r_sat_s;
    logic          r_in_s;

    always_comb begin
        if (w_di_d[DTW]) begin
            n_num = NUM_IN;
            n_den = DW'(w_pr2);
        end else begin
            n_num = {w_di_d[DTW-1:0], {NSH{1'b0}}};
            n_den = w_den_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_den   <= n_den;
        r_sat_s <= (n_den == '0) || (XW2'(n_num) >= (XW2'(n_den) << W));
        r_in_s  <= w_di_d[DTW];
    end

    // ------------------------------------------------------------------
    // final quotient and result register
    // ------------------------------------------------------------------
    logic [W-1:0] w_dens;
    logic [1:0]   w_flags_d;
    t_result      r_res;

    slpdf_div #(.ND(NW), .DD(DW), .QB(W)) u_div_out (
        .i_clk (i_clk), .i_num (r_num), .i_den (r_den), .o_q (w_dens)
    );

    slpdf_dly #(.WIDTH(2), .DEPTH(W)) u_dly_flags (
        .i_clk (i_clk), .i_d ({r_in_s, r_sat_s}), .o_d (w_flags_d)
    );

    always_ff @(posedge i_clk) begin
        r_res.density       <= w_flags_d[0] ? '1 : w_dens;
        r_res.inside_sphere <= w_flags_d[1];
        r_res.saturated     <= w_flags_d[0];
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

@@ src/slpdf_chk.sv @@
// ============================================================================
// slpdf_chk
// Port-level checks for sphere_light_sample_pdf, attached by bind.
// ============================================================================
`default_nettype none

module slpdf_chk
    import slpdf_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    busy,
    input wire logic    o_valid,
    input wire t_result o_result
);

    // a clamped transaction always carries the maximum density
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.saturated |-> o_result.density == '1)
        else $error("saturated result without maximum density");

    // reset flushes every transaction in flight
    a_rst_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // no query is taken while in reset
    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

endmodule

bind sphere_light_sample_pdf slpdf_chk u_slpdf_chk (.*);

`default_nettype wire
